@@ src/tbf_pkg.sv @@
// Shared types, constants and a helper function for the tape block framer.
`timescale 1ns / 1ps

package tbf_pkg;

  // Default framing parameters
  localparam int LEADER_ONES_DEF = 16;
  localparam int BLOCK_LIMIT_DEF = 254;

  // Fixed format figures
  localparam int SIZE_OVERHEAD = 12;
  localparam int FILE_SIZE_MAX = 65535;
  localparam int NAME_LEN      = 11;
  localparam int NAME_CNT_W    = $clog2(NAME_LEN);
  localparam int TOT_W         = 17;
  localparam int QUEUE_DEPTH   = 4;
  localparam logic [7:0] HEAD_BYTES = 8'd5;

  // Tape byte values
  localparam logic [7:0] LEAD_BYTE   = 8'h01;
  localparam logic [7:0] SYNC_A      = 8'h3C;
  localparam logic [7:0] SYNC_B      = 8'h5A;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;
  localparam logic [7:0] NAME_TYPE   = 8'h10;
  localparam logic [7:0] NAME_TAIL   = 8'h02;
  localparam logic [7:0] BLOCK_MARK  = 8'h01;
  localparam logic [7:0] END_MARK    = 8'hFF;
  localparam logic [7:0] END_TYPE    = 8'h02;

  // Input action codes
  localparam logic [1:0] ACT_BEGIN   = 2'd0;
  localparam logic [1:0] ACT_PAYLOAD = 2'd1;
  localparam logic [1:0] ACT_FINISH  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_ADDRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXEC_ADDRESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_FIRST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LAST    = 3'd4;

  // Configuration reset values
  localparam logic [15:0] RST_FILE_SIZE    = 16'h0000;
  localparam logic [15:0] RST_LOAD_ADDRESS = 16'h3000;
  localparam logic [15:0] RST_EXEC_ADDRESS = 16'h3000;
  localparam logic [63:0] RST_NAME_FIRST   = 64'h6D61_696E_2020_2020;
  localparam logic [23:0] RST_NAME_LAST    = 24'h65_7865;

  typedef struct packed {
    logic [15:0] file_size;
    logic [15:0] load_address;
    logic [15:0] exec_address;
    logic [63:0] name_first_eight;
    logic [23:0] name_last_three;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_BEGIN,
    CMD_PAYLOAD,
    CMD_FINISH
  } cmd_kind_t;

  // One classified item handed from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    logic       close;    // payload closes the current block first
    logic [7:0] data;
    logic [7:0] csum;     // block checksum (close or trailer)
    logic [7:0] hdr_len;  // length byte of the next block header
  } cmd_t;

  typedef enum logic [1:0] {
    FS_ACCEPT,
    FS_DIV,
    FS_PUSH
  } front_state_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_LEAD_ONE,
    PH_LEAD_3C,
    PH_LEAD_5A,
    PH_NAME_HDR0,
    PH_NAME_HDR1,
    PH_NAME,
    PH_NAME_T0,
    PH_NAME_T1,
    PH_NAME_T2,
    PH_NAME_SUM,
    PH_BLK_HDR0,
    PH_BLK_HDR1,
    PH_BLK_HDR2,
    PH_SIZE_HI,
    PH_SIZE_LO,
    PH_LOAD_HI,
    PH_LOAD_LO,
    PH_CSUM,
    PH_DATA,
    PH_END0,
    PH_END1,
    PH_END2,
    PH_EXEC_HI,
    PH_EXEC_LO,
    PH_END_SUM,
    PH_MARK0,
    PH_MARK1,
    PH_MARK2
  } phase_t;

  // Two's complement of a byte sum
  function automatic logic [7:0] complement(input logic [7:0] s);
    complement = 8'(9'h100 - {1'b0, s});
  endfunction

endpackage

@@ src/tbf_in_if.sv @@
// Input item channel: action code and payload byte.
`timescale 1ns / 1ps

interface tbf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

@@ src/tbf_out_if.sv @@
// Result item channel: one tape byte with its last flag.
`timescale 1ns / 1ps

interface tbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tape_byte;
  logic       last;

  modport source (output valid, output tape_byte, output last, input ready);
  modport sink   (input valid, input tape_byte, input last, output ready);
endinterface

@@ src/tbf_queue.sv @@
// Small command queue between the front classifier and the back sequencer.
`timescale 1ns / 1ps

module tbf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tbf_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output tbf_pkg::cmd_t pop_data,
  output logic          empty
);
  import tbf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/tbf_front.sv @@
// Front end: accepts items, tracks block state and classifies into commands.
`timescale 1ns / 1ps

module tbf_front #(
  parameter int BLOCK_LIMIT = tbf_pkg::BLOCK_LIMIT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  tbf_in_if.sink        in_ch,
  input  logic [15:0]   file_size,
  input  logic [15:0]   load_address,
  input  logic [15:0]   exec_address,
  input  logic          q_full,
  output logic          q_push,
  output tbf_pkg::cmd_t q_data
);
  import tbf_pkg::*;

  localparam int BL_MAX = (FILE_SIZE_MAX + SIZE_OVERHEAD) / BLOCK_LIMIT;
  localparam int BL_W   = $clog2(BL_MAX + 1);
  localparam logic [7:0] LIMIT8 = 8'(BLOCK_LIMIT);

  // Reciprocal of the block limit, exact floor for any TOT_W-bit total
  localparam int RECIP_SHIFT = TOT_W + 8;
  localparam int RECIP_W     = RECIP_SHIFT - 3;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + BLOCK_LIMIT - 1) / BLOCK_LIMIT);
  localparam int PROD_W      = TOT_W + RECIP_W;

  front_state_t         fs_r, fs_nxt;
  logic [7:0]           rs_r, rs_nxt;     // running block sum
  logic [7:0]           bb_r, bb_nxt;     // bytes in current block
  logic [BL_W-1:0]      bl_r, bl_nxt;     // full blocks still to close
  logic [7:0]           fl_r, fl_nxt;     // last block length

  // Block count: total, then quotient by reciprocal multiply
  logic [TOT_W-1:0]     dvd_r, dvd_nxt;
  logic [BL_W-1:0]      quo_r, quo_nxt;

  logic [PROD_W-1:0] prod;
  logic [TOT_W-1:0]  qmul;
  logic [7:0]        rem_cur;
  logic            close;
  logic [BL_W-1:0] bl_dec;
  logic [7:0]      hdr_close;
  logic [7:0]      fin_sum;
  logic [7:0]      head_sum;

  assign in_ch.ready = (fs_r == FS_ACCEPT) && !q_full;

  // Block count arithmetic and per-item arithmetic
  always_comb begin
    prod      = {{RECIP_W{1'b0}}, dvd_r} * {{TOT_W{1'b0}}, RECIP};
    qmul      = TOT_W'(quo_r) * TOT_W'(LIMIT8);
    rem_cur   = 8'(dvd_r - qmul);
    close     = (bb_r >= LIMIT8);
    bl_dec    = (bl_r != '0) ? bl_r - 1'b1 : '0;
    hdr_close = (bl_dec != '0) ? ZERO_BYTE : fl_r;
    fin_sum   = rs_r + END_MARK + exec_address[15:8] + exec_address[7:0];
    head_sum  = file_size[15:8] + file_size[7:0] + load_address[15:8] + load_address[7:0];
  end

  // Classification and state update
  always_comb begin
    fs_nxt  = fs_r;
    rs_nxt  = rs_r;
    bb_nxt  = bb_r;
    bl_nxt  = bl_r;
    fl_nxt  = fl_r;
    dvd_nxt = dvd_r;
    quo_nxt = quo_r;
    q_push  = 1'b0;
    q_data  = '0;
    case (fs_r)
      FS_ACCEPT: begin
        if (in_ch.valid && in_ch.ready) begin
          case (in_ch.action)
            ACT_BEGIN: begin
              dvd_nxt = TOT_W'(file_size) + TOT_W'(SIZE_OVERHEAD);
              fs_nxt  = FS_DIV;
            end
            ACT_PAYLOAD: begin
              q_push         = 1'b1;
              q_data.kind    = CMD_PAYLOAD;
              q_data.close   = close;
              q_data.data    = in_ch.data_byte;
              q_data.csum    = complement(rs_r);
              q_data.hdr_len = hdr_close;
              if (close) begin
                bl_nxt = bl_dec;
                rs_nxt = in_ch.data_byte;
                bb_nxt = 8'd1;
              end else begin
                rs_nxt = rs_r + in_ch.data_byte;
                bb_nxt = bb_r + 8'd1;
              end
            end
            ACT_FINISH: begin
              q_push      = 1'b1;
              q_data.kind = CMD_FINISH;
              q_data.csum = complement(fin_sum);
              rs_nxt      = '0;
            end
            default: ;
          endcase
        end
      end
      FS_DIV: begin
        quo_nxt = prod[RECIP_SHIFT +: BL_W];
        fs_nxt  = FS_PUSH;
      end
      FS_PUSH: begin
        if (!q_full) begin
          q_push         = 1'b1;
          q_data.kind    = CMD_BEGIN;
          q_data.hdr_len = (quo_r != '0) ? ZERO_BYTE : rem_cur;
          bl_nxt         = quo_r;
          fl_nxt         = rem_cur;
          rs_nxt         = head_sum;
          bb_nxt         = HEAD_BYTES;
          fs_nxt         = FS_ACCEPT;
        end
      end
      default: fs_nxt = FS_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_ACCEPT;
      rs_r <= '0;
      bb_r <= '0;
      bl_r <= '0;
      fl_r <= '0;
    end else begin
      fs_r <= fs_nxt;
      rs_r <= rs_nxt;
      bb_r <= bb_nxt;
      bl_r <= bl_nxt;
      fl_r <= fl_nxt;
    end
  end

  // Block count datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

endmodule

@@ src/tbf_back.sv @@
// Back end: steps through the tape byte sequence of each command.
`timescale 1ns / 1ps

module tbf_back #(
  parameter int LEADER_ONES = tbf_pkg::LEADER_ONES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tbf_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  tbf_pkg::cmd_t q_data,
  output logic          q_pop,
  tbf_out_if.source     out_ch
);
  import tbf_pkg::*;

  localparam int LC_W = (LEADER_ONES > 1) ? $clog2(LEADER_ONES) : 1;
  localparam logic [LC_W-1:0] LEAD_LAST = LC_W'(LEADER_ONES - 1);
  localparam logic [NAME_CNT_W-1:0] NAME_LAST = NAME_CNT_W'(NAME_LEN - 1);

  phase_t                phase_r, phase_nxt;
  cmd_t                  cmd_r;
  logic                  second_r, second_nxt;   // in the second leader of a begin
  logic [LC_W-1:0]       lead_cnt_r, lead_cnt_nxt;
  logic [NAME_CNT_W-1:0] name_cnt_r, name_cnt_nxt;
  logic [7:0]            nsum_r, nsum_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic                  out_last_r, out_last_nxt;

  logic       out_free;
  logic       step;
  logic       load;
  logic [7:0] cur_byte;
  logic       cur_last;
  phase_t     after_phase;
  phase_t     first_phase;
  logic [7:0] name_byte;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.tape_byte = out_byte_r;
  assign out_ch.last      = out_last_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign step     = (phase_r != PH_IDLE) && out_free;
  assign load     = !q_empty && ((phase_r == PH_IDLE) || (step && cur_last));
  assign q_pop    = load;

  // Name byte select, first character in the top byte
  always_comb begin
    if (name_cnt_r < NAME_CNT_W'(8)) begin
      name_byte = cfg.name_first_eight[{~name_cnt_r[2:0], 3'b000} +: 8];
    end else begin
      name_byte = cfg.name_last_three[{2'(NAME_LAST - name_cnt_r), 3'b000} +: 8];
    end
  end

  // Entry phase of the command at the queue head
  always_comb begin
    case (q_data.kind)
      CMD_BEGIN:   first_phase = PH_LEAD_ONE;
      CMD_PAYLOAD: first_phase = q_data.close ? PH_CSUM : PH_DATA;
      CMD_FINISH:  first_phase = PH_END0;
      default:     first_phase = PH_IDLE;
    endcase
  end

  // Byte of the current phase and the phase that follows it
  always_comb begin
    cur_byte    = ZERO_BYTE;
    cur_last    = 1'b0;
    after_phase = PH_IDLE;
    case (phase_r)
      PH_LEAD_ONE: begin
        cur_byte    = LEAD_BYTE;
        after_phase = (lead_cnt_r == LEAD_LAST) ? PH_LEAD_3C : PH_LEAD_ONE;
      end
      PH_LEAD_3C: begin
        cur_byte    = SYNC_A;
        after_phase = PH_LEAD_5A;
      end
      PH_LEAD_5A: begin
        cur_byte = SYNC_B;
        case (cmd_r.kind)
          CMD_BEGIN:  after_phase = second_r ? PH_BLK_HDR0 : PH_NAME_HDR0;
          CMD_FINISH: after_phase = PH_MARK0;
          default:    after_phase = PH_BLK_HDR0;
        endcase
      end
      PH_NAME_HDR0: after_phase = PH_NAME_HDR1;
      PH_NAME_HDR1: begin
        cur_byte    = NAME_TYPE;
        after_phase = PH_NAME;
      end
      PH_NAME: begin
        cur_byte    = name_byte;
        after_phase = (name_cnt_r == NAME_LAST) ? PH_NAME_T0 : PH_NAME;
      end
      PH_NAME_T0: begin
        cur_byte    = NAME_TAIL;
        after_phase = PH_NAME_T1;
      end
      PH_NAME_T1: after_phase = PH_NAME_T2;
      PH_NAME_T2: after_phase = PH_NAME_SUM;
      PH_NAME_SUM: begin
        cur_byte    = complement(nsum_r + NAME_TAIL);
        after_phase = PH_LEAD_ONE;
      end
      PH_BLK_HDR0: begin
        cur_byte    = BLOCK_MARK;
        after_phase = PH_BLK_HDR1;
      end
      PH_BLK_HDR1: begin
        cur_byte    = cmd_r.hdr_len;
        after_phase = (cmd_r.kind == CMD_BEGIN) ? PH_BLK_HDR2 : PH_DATA;
      end
      PH_BLK_HDR2: after_phase = PH_SIZE_HI;
      PH_SIZE_HI: begin
        cur_byte    = cfg.file_size[15:8];
        after_phase = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        cur_byte    = cfg.file_size[7:0];
        after_phase = PH_LOAD_HI;
      end
      PH_LOAD_HI: begin
        cur_byte    = cfg.load_address[15:8];
        after_phase = PH_LOAD_LO;
      end
      PH_LOAD_LO: begin
        cur_byte = cfg.load_address[7:0];
        cur_last = 1'b1;
      end
      PH_CSUM: begin
        cur_byte    = cmd_r.csum;
        after_phase = PH_LEAD_ONE;
      end
      PH_DATA: begin
        cur_byte = cmd_r.data;
        cur_last = 1'b1;
      end
      PH_END0: begin
        cur_byte    = END_MARK;
        after_phase = PH_END1;
      end
      PH_END1: after_phase = PH_END2;
      PH_END2: after_phase = PH_EXEC_HI;
      PH_EXEC_HI: begin
        cur_byte    = cfg.exec_address[15:8];
        after_phase = PH_EXEC_LO;
      end
      PH_EXEC_LO: begin
        cur_byte    = cfg.exec_address[7:0];
        after_phase = PH_END_SUM;
      end
      PH_END_SUM: begin
        cur_byte    = cmd_r.csum;
        after_phase = PH_LEAD_ONE;
      end
      PH_MARK0: begin
        cur_byte    = END_MARK;
        after_phase = PH_MARK1;
      end
      PH_MARK1: begin
        cur_byte    = END_TYPE;
        after_phase = PH_MARK2;
      end
      PH_MARK2: cur_last = 1'b1;
      default: ;
    endcase
  end

  // Sequencer and output register update
  always_comb begin
    phase_nxt     = phase_r;
    second_nxt    = second_r;
    lead_cnt_nxt  = lead_cnt_r;
    name_cnt_nxt  = name_cnt_r;
    nsum_nxt      = nsum_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (out_free) begin
      out_valid_nxt = step;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = cur_last;
    end

    if (step) begin
      phase_nxt = cur_last ? PH_IDLE : after_phase;
      if (phase_r == PH_LEAD_ONE) begin
        lead_cnt_nxt = (lead_cnt_r == LEAD_LAST) ? '0 : lead_cnt_r + 1'b1;
      end
      if (phase_r == PH_NAME_HDR0) begin
        nsum_nxt = '0;
      end
      if (phase_r == PH_NAME) begin
        name_cnt_nxt = (name_cnt_r == NAME_LAST) ? '0 : name_cnt_r + 1'b1;
        nsum_nxt     = nsum_r + name_byte;
      end
      if (phase_r == PH_NAME_SUM) begin
        second_nxt = 1'b1;
      end
    end

    if (load) begin
      phase_nxt  = first_phase;
      second_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      second_r    <= 1'b0;
      lead_cnt_r  <= '0;
      name_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      second_r    <= second_nxt;
      lead_cnt_r  <= lead_cnt_nxt;
      name_cnt_r  <= name_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    nsum_r     <= nsum_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (load) begin
      cmd_r <= q_data;
    end
  end

endmodule

@@ src/tape_block_framer.sv @@
// Top level of the tape block framer: configuration registers and front/back wiring.
//
//   channel   dir   payload                        handshake
//   in_ch     in    action[1:0], data_byte[7:0]    valid/ready
//   out_ch    out   tape_byte[7:0], last           valid/ready
//   cfg_*     in    cfg_index[2:0], cfg_wdata[63:0] cfg_we, no back-pressure
//
// Output runs at one tape byte per cycle unless out_ch stalls; output stalls push
// back through the queue. A payload item that fits its block is taken every cycle
// while the queue has room. A begin item holds the input through FS_DIV, which
// registers the block count from the reciprocal multiply, and FS_PUSH, which forms
// the last block length and queues the command, waiting on a full queue; the back
// end keeps draining a four-entry queue. Reset is synchronous; no clearing pass.
`timescale 1ns / 1ps

module tape_block_framer #(
  parameter int LEADER_ONES = tbf_pkg::LEADER_ONES_DEF,
  parameter int BLOCK_LIMIT = tbf_pkg::BLOCK_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tbf_in_if.sink                         in_ch,
  tbf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tbf_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FILE_SIZE:    cfg_nxt.file_size        = cfg_wdata[15:0];
        CFG_LOAD_ADDRESS: cfg_nxt.load_address     = cfg_wdata[15:0];
        CFG_EXEC_ADDRESS: cfg_nxt.exec_address     = cfg_wdata[15:0];
        CFG_NAME_FIRST:   cfg_nxt.name_first_eight = cfg_wdata;
        CFG_NAME_LAST:    cfg_nxt.name_last_three  = cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.file_size        <= RST_FILE_SIZE;
      cfg_r.load_address     <= RST_LOAD_ADDRESS;
      cfg_r.exec_address     <= RST_EXEC_ADDRESS;
      cfg_r.name_first_eight <= RST_NAME_FIRST;
      cfg_r.name_last_three  <= RST_NAME_LAST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tbf_front #(
    .BLOCK_LIMIT (BLOCK_LIMIT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .file_size    (cfg_r.file_size),
    .load_address (cfg_r.load_address),
    .exec_address (cfg_r.exec_address),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  tbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  tbf_back #(
    .LEADER_ONES (LEADER_ONES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
